>>> src/lrd_pkg.sv
`default_nettype none
package lrd_pkg;

   localparam int SCREEN_BITS = 12;
   localparam int COLOR_BITS  = 24;

   typedef enum logic [0:0] {
      CSR_SCREEN_WIDTH  = 1'b0,
      CSR_SCREEN_HEIGHT = 1'b1
   } csr_index_type;

   localparam logic [SCREEN_BITS-1:0] SCREEN_WIDTH_RESET  = 12'd640;
   localparam logic [SCREEN_BITS-1:0] SCREEN_HEIGHT_RESET = 12'd480;

   typedef enum logic [0:0] {
      FUNC_START = 1'b0,
      FUNC_TICK  = 1'b1
   } func_type;

   typedef enum logic [0:0] {
      ST_IDLE   = 1'b0,
      ST_DIVIDE = 1'b1
   } lrd_state_type;

endpackage
`default_nettype wire

>>> src/line_rasterizer_with_depth.sv
// A tick transaction's result is registered and appears in the cycle after acceptance, and
// the block is ready again at once, so ticks stream at one per cycle while responses are taken.
// A start transaction whose line has more than one pixel runs the radix-2 divider and takes
// no new request meanwhile; pixel 0 is registered when the divider signals done.
// Dropped lines and single points are answered in the cycle after acceptance.
// Synchronous active-high reset clears the control state and restores 640 by 480.
`default_nettype none
module line_rasterizer_with_depth
   import lrd_pkg::*;
#(
   parameter int COORD_BITS = 13,
   parameter int DEPTH_BITS = 24
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_func,
   input  wire logic [COORD_BITS-1:0]  req_start_x,
   input  wire logic [COORD_BITS-1:0]  req_start_y,
   input  wire logic [DEPTH_BITS-1:0]  req_start_depth,
   input  wire logic [COORD_BITS-1:0]  req_end_x,
   input  wire logic [COORD_BITS-1:0]  req_end_y,
   input  wire logic [DEPTH_BITS-1:0]  req_end_depth,
   input  wire logic [COLOR_BITS-1:0]  req_line_color,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_active,
   output logic [COORD_BITS-1:0]       rsp_pixel_x,
   output logic [COORD_BITS-1:0]       rsp_pixel_y,
   output logic [DEPTH_BITS-1:0]       rsp_pixel_depth,
   output logic [COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                        rsp_visible,
   output logic                        rsp_last,
   input  wire logic                   csr_write_enable,
   input  wire logic [0:0]             csr_index,
   input  wire logic [SCREEN_BITS-1:0] csr_write_data
);

   localparam int VW = ((COORD_BITS > SCREEN_BITS) ? COORD_BITS : SCREEN_BITS) + 1;
   localparam int DW = COORD_BITS + 3;

   lrd_state_type state_ff, state_in;

   logic [SCREEN_BITS-1:0] width_ff, height_ff;

   logic                  line_active_ff, line_active_in;
   logic [COORD_BITS-1:0] cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0] cur_row_ff, cur_row_in;
   logic [DW-1:0]         decision_ff, decision_in;
   logic [COORD_BITS-1:0] steps_left_ff, steps_left_in;
   logic                  major_is_col_ff, major_is_col_in;
   logic                  row_down_ff, row_down_in;
   logic [COORD_BITS-1:0] minor_ff, minor_in;
   logic [COORD_BITS-1:0] major_ff, major_in;
   logic [DEPTH_BITS-1:0] cur_depth_ff, cur_depth_in;
   logic [DEPTH_BITS:0]   quotient_ff, quotient_in;
   logic [COORD_BITS-1:0] remainder_ff, remainder_in;
   logic [COORD_BITS-1:0] accum_ff, accum_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;
   logic                  negative_ff, negative_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_active_ff, rsp_active_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_x_in;
   logic [COORD_BITS-1:0] rsp_y_ff, rsp_y_in;
   logic [DEPTH_BITS-1:0] rsp_depth_ff, rsp_depth_in;
   logic [COLOR_BITS-1:0] rsp_color_ff, rsp_color_in;
   logic                  rsp_visible_ff, rsp_visible_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  swap;
   logic [COORD_BITS-1:0] x1, y1, x2, y2;
   logic [DEPTH_BITS-1:0] z1, z2;
   logic [VW-1:0]         x1e, y1e, x2e, y2e, we, he;
   logic                  dropped;
   logic [COORD_BITS-1:0] dx, ady, n_major, n_minor;
   logic [COORD_BITS:0]   dy_full, ady_full;
   logic                  dy_down, major_col;
   logic [DEPTH_BITS:0]   diff;
   logic [DEPTH_BITS:0]   diff_mag;
   logic                  div_start, div_done;
   logic [DEPTH_BITS-1:0] div_quotient;
   logic [COORD_BITS-1:0] div_remainder;

   logic                  diag;
   logic [COORD_BITS:0]   accum_sum;
   logic                  depth_carry;
   logic [COORD_BITS-1:0] pix_col, pix_row;
   logic [VW-1:0]         pix_col_e, pix_row_e;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      swap = $signed(req_end_x) < $signed(req_start_x);
      x1 = swap ? req_end_x : req_start_x;
      y1 = swap ? req_end_y : req_start_y;
      z1 = swap ? req_end_depth : req_start_depth;
      x2 = swap ? req_start_x : req_end_x;
      y2 = swap ? req_start_y : req_end_y;
      z2 = swap ? req_start_depth : req_end_depth;
      x1e = {{(VW-COORD_BITS){x1[COORD_BITS-1]}}, x1};
      y1e = {{(VW-COORD_BITS){y1[COORD_BITS-1]}}, y1};
      x2e = {{(VW-COORD_BITS){x2[COORD_BITS-1]}}, x2};
      y2e = {{(VW-COORD_BITS){y2[COORD_BITS-1]}}, y2};
      we  = {{(VW-SCREEN_BITS){1'b0}}, width_ff};
      he  = {{(VW-SCREEN_BITS){1'b0}}, height_ff};
      dropped = (x1[COORD_BITS-1] && x2[COORD_BITS-1]) ||
                (y1[COORD_BITS-1] && y2[COORD_BITS-1]) ||
                ($signed(x1e) > $signed(we) && $signed(x2e) > $signed(we)) ||
                ($signed(y1e) > $signed(he) && $signed(y2e) > $signed(he));
      dx       = x2 - x1;
      dy_full  = {y2[COORD_BITS-1], y2} - {y1[COORD_BITS-1], y1};
      dy_down  = dy_full[COORD_BITS];
      ady_full = dy_down ? -dy_full : dy_full;
      ady      = ady_full[COORD_BITS-1:0];
      major_col = ady <= dx;
      n_major  = major_col ? dx : ady;
      n_minor  = major_col ? ady : dx;
      diff     = {1'b0, z2} - {1'b0, z1};
      diff_mag = diff[DEPTH_BITS] ? -diff : diff;
   end

   assign div_start = accept && (req_func == FUNC_START) && !dropped && (n_major != '0);

   lrd_divider #(
      .DIVIDEND_BITS(DEPTH_BITS),
      .DIVISOR_BITS (COORD_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_mag[DEPTH_BITS-1:0]),
      .divisor  (n_major),
      .done     (div_done),
      .quotient (div_quotient),
      .remainder(div_remainder)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (div_start) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      diag        = !decision_ff[DW-1];
      accum_sum   = {1'b0, accum_ff} + {1'b0, remainder_ff};
      depth_carry = accum_sum >= {1'b0, major_ff};

      line_active_in  = line_active_ff;
      cur_col_in      = cur_col_ff;
      cur_row_in      = cur_row_ff;
      decision_in     = decision_ff;
      steps_left_in   = steps_left_ff;
      major_is_col_in = major_is_col_ff;
      row_down_in     = row_down_ff;
      minor_in        = minor_ff;
      major_in        = major_ff;
      cur_depth_in    = cur_depth_ff;
      quotient_in     = quotient_ff;
      remainder_in    = remainder_ff;
      accum_in        = accum_ff;
      color_in        = color_ff;
      negative_in     = negative_ff;

      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_active_in  = rsp_active_ff;
      rsp_x_in       = rsp_x_ff;
      rsp_y_in       = rsp_y_ff;
      rsp_depth_in   = rsp_depth_ff;
      rsp_color_in   = rsp_color_ff;
      rsp_last_in    = rsp_last_ff;
      pix_col        = cur_col_ff;
      pix_row        = cur_row_ff;

      if (state_ff == ST_DIVIDE) begin
         if (div_done) begin
            if (negative_ff && (div_remainder != '0)) begin
               quotient_in  = ~{1'b0, div_quotient};
               remainder_in = major_ff - div_remainder;
            end else if (negative_ff) begin
               quotient_in  = -{1'b0, div_quotient};
               remainder_in = '0;
            end else begin
               quotient_in  = {1'b0, div_quotient};
               remainder_in = div_remainder;
            end
            line_active_in = 1'b1;
            rsp_valid_in   = 1'b1;
            rsp_active_in  = 1'b1;
            rsp_x_in       = cur_col_ff;
            rsp_y_in       = cur_row_ff;
            rsp_depth_in   = cur_depth_ff;
            rsp_color_in   = color_ff;
            rsp_last_in    = 1'b0;
         end
      end else if (accept) begin
         rsp_valid_in = 1'b1;
         if (req_func == FUNC_START) begin
            line_active_in = 1'b0;
            if (dropped) begin
               rsp_active_in = 1'b0;
               rsp_x_in      = '0;
               rsp_y_in      = '0;
               rsp_depth_in  = '0;
               rsp_color_in  = '0;
               rsp_last_in   = 1'b0;
            end else begin
               row_down_in     = dy_down;
               major_is_col_in = major_col;
               major_in        = n_major;
               minor_in        = n_minor;
               decision_in     = {2'b00, n_minor, 1'b0} - {3'b000, n_major};
               cur_col_in      = x1;
               cur_row_in      = y1;
               cur_depth_in    = z1;
               color_in        = req_line_color;
               steps_left_in   = n_major;
               accum_in        = '0;
               negative_in     = diff[DEPTH_BITS];
               quotient_in     = '0;
               remainder_in    = '0;
               pix_col         = x1;
               pix_row         = y1;
               if (n_major == '0) begin
                  rsp_active_in = 1'b1;
                  rsp_x_in      = x1;
                  rsp_y_in      = y1;
                  rsp_depth_in  = z1;
                  rsp_color_in  = req_line_color;
                  rsp_last_in   = 1'b1;
               end else begin
                  rsp_valid_in = 1'b0;
               end
            end
         end else if (line_active_ff) begin
            decision_in = diag ?
               decision_ff + {2'b00, minor_ff, 1'b0} - {2'b00, major_ff, 1'b0} :
               decision_ff + {2'b00, minor_ff, 1'b0};
            if (major_is_col_ff || diag) begin
               cur_col_in = cur_col_ff + 1'b1;
            end
            if (!major_is_col_ff || diag) begin
               cur_row_in = row_down_ff ? cur_row_ff - 1'b1 : cur_row_ff + 1'b1;
            end
            cur_depth_in = cur_depth_ff + quotient_ff[DEPTH_BITS-1:0] +
                           {{(DEPTH_BITS-1){1'b0}}, depth_carry};
            accum_in = depth_carry ? COORD_BITS'(accum_sum - {1'b0, major_ff})
                                   : accum_sum[COORD_BITS-1:0];
            steps_left_in  = steps_left_ff - 1'b1;
            line_active_in = steps_left_ff != {{(COORD_BITS-1){1'b0}}, 1'b1};
            pix_col        = cur_col_in;
            pix_row        = cur_row_in;
            rsp_active_in  = 1'b1;
            rsp_x_in       = cur_col_in;
            rsp_y_in       = cur_row_in;
            rsp_depth_in   = cur_depth_in;
            rsp_color_in   = color_ff;
            rsp_last_in    = !line_active_in;
         end else begin
            line_active_in = 1'b0;
            rsp_active_in  = 1'b0;
            rsp_x_in       = '0;
            rsp_y_in       = '0;
            rsp_depth_in   = '0;
            rsp_color_in   = '0;
            rsp_last_in    = 1'b0;
         end
      end

      pix_col_e = {{(VW-COORD_BITS){pix_col[COORD_BITS-1]}}, pix_col};
      pix_row_e = {{(VW-COORD_BITS){pix_row[COORD_BITS-1]}}, pix_row};
      rsp_visible_in = rsp_active_in &&
                       !pix_col[COORD_BITS-1] && !pix_row[COORD_BITS-1] &&
                       ($signed(pix_col_e) < $signed(we)) &&
                       ($signed(pix_row_e) < $signed(he));
      if (!(rsp_valid_in && !(rsp_valid_ff && !rsp_ready))) begin
         rsp_visible_in = rsp_visible_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         width_ff       <= SCREEN_WIDTH_RESET;
         height_ff      <= SCREEN_HEIGHT_RESET;
         line_active_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         line_active_ff <= line_active_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_write_enable) begin
            unique case (csr_index_type'(csr_index))
               CSR_SCREEN_WIDTH:  width_ff  <= csr_write_data;
               CSR_SCREEN_HEIGHT: height_ff <= csr_write_data;
               default: ;
            endcase
         end
      end
      cur_col_ff      <= cur_col_in;
      cur_row_ff      <= cur_row_in;
      decision_ff     <= decision_in;
      steps_left_ff   <= steps_left_in;
      major_is_col_ff <= major_is_col_in;
      row_down_ff     <= row_down_in;
      minor_ff        <= minor_in;
      major_ff        <= major_in;
      cur_depth_ff    <= cur_depth_in;
      quotient_ff     <= quotient_in;
      remainder_ff    <= remainder_in;
      accum_ff        <= accum_in;
      color_ff        <= color_in;
      negative_ff     <= negative_in;
      rsp_active_ff   <= rsp_active_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
      rsp_depth_ff    <= rsp_depth_in;
      rsp_color_ff    <= rsp_color_in;
      rsp_visible_ff  <= rsp_visible_in;
      rsp_last_ff     <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_active      = rsp_active_ff;
   assign rsp_pixel_x     = rsp_x_ff;
   assign rsp_pixel_y     = rsp_y_ff;
   assign rsp_pixel_depth = rsp_depth_ff;
   assign rsp_pixel_color = rsp_color_ff;
   assign rsp_visible     = rsp_visible_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

>>> src/lrd_divider.sv
`default_nettype none
module lrd_divider
   import lrd_pkg::*;
#(
   parameter int DIVIDEND_BITS = 24,
   parameter int DIVISOR_BITS  = 13
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   input  wire logic [DIVIDEND_BITS-1:0] dividend,
   input  wire logic [DIVISOR_BITS-1:0]  divisor,
   output logic                          done,
   output logic [DIVIDEND_BITS-1:0]      quotient,
   output logic [DIVISOR_BITS-1:0]       remainder
);

   localparam int CNT_BITS = (DIVIDEND_BITS > 1) ? $clog2(DIVIDEND_BITS) : 1;

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   logic [DIVIDEND_BITS-1:0] quo_ff, quo_in;
   logic [DIVISOR_BITS-1:0]  rem_ff, rem_in;
   logic [DIVISOR_BITS-1:0]  div_ff, div_in;
   logic [DIVISOR_BITS:0]    shifted;
   logic [DIVISOR_BITS:0]    trial;

   always_comb begin
      shifted  = {rem_ff, quo_ff[DIVIDEND_BITS-1]};
      trial    = shifted - {1'b0, div_ff};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(DIVIDEND_BITS - 1);
         quo_in   = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (busy_ff) begin
         if (!trial[DIVISOR_BITS]) begin
            rem_in = trial[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
         end else begin
            rem_in = shifted[DIVISOR_BITS-1:0];
            quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
         end
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

>>> dv/tb_line_rasterizer_with_depth.sv
module tb_line_rasterizer_with_depth;
   import lrd_pkg::*;

   localparam int COORD_W = 13;
   localparam int DEPTH_W = 24;
   localparam int CYCLE_LIMIT = 1_000_000;

   typedef struct packed {
      func_type              func;
      logic [COORD_W-1:0]    start_x;
      logic [COORD_W-1:0]    start_y;
      logic [DEPTH_W-1:0]    start_depth;
      logic [COORD_W-1:0]    end_x;
      logic [COORD_W-1:0]    end_y;
      logic [DEPTH_W-1:0]    end_depth;
      logic [COLOR_BITS-1:0] color;
   } line_cmd_type;

   typedef struct packed {
      logic                  active;
      logic [COORD_W-1:0]    x;
      logic [COORD_W-1:0]    y;
      logic [DEPTH_W-1:0]    depth;
      logic [COLOR_BITS-1:0] color;
      logic                  visible;
      logic                  last;
   } pixel_type;

   typedef struct packed {
      line_cmd_type cmd;
      logic         known;
      pixel_type    want;
   } directed_row_type;

   localparam pixel_type NO_PIXEL = '0;
   localparam line_cmd_type TICK_CMD =
      '{FUNC_TICK, 13'd0, 13'd0, 24'd0, 13'd0, 13'd0, 24'd0, 24'd0};

   // Rows with known set carry the expected pixel; the others are checked against the predictor.
   localparam directed_row_type PLAN [24] = '{
      '{TICK_CMD, 1'b1, NO_PIXEL},
      '{'{FUNC_START, -13'sd5, 13'd10, 24'h000010, -13'sd1, 13'd20, 24'h000020, 24'h111111},
        1'b1, NO_PIXEL},
      '{'{FUNC_START, 13'd3, -13'sd1, 24'h000000, 13'd300, 13'h1000, 24'hFFFFFF, 24'h222222},
        1'b1, NO_PIXEL},
      '{'{FUNC_START, 13'd4095, 13'd0, 24'h000005, 13'd641, 13'd10, 24'h000007, 24'h333333},
        1'b1, NO_PIXEL},
      '{'{FUNC_START, 13'd0, 13'd481, 24'h000005, 13'd10, 13'd4095, 24'h000007, 24'h444444},
        1'b1, NO_PIXEL},
      '{'{FUNC_START, 13'd640, 13'd0, 24'h000100, 13'd640, 13'd3, 24'h000000, 24'h5A5A5A},
        1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b1, NO_PIXEL},
      '{'{FUNC_START, 13'd0, 13'd0, 24'hFFFFFF, 13'd0, 13'd0, 24'hFFFFFF, 24'hFFFFFF},
        1'b1, '{1'b1, 13'd0, 13'd0, 24'hFFFFFF, 24'hFFFFFF, 1'b1, 1'b1}},
      '{'{FUNC_START, 13'd639, 13'd479, 24'h000000, 13'd639, 13'd479, 24'h000000, 24'h000000},
        1'b1, '{1'b1, 13'd639, 13'd479, 24'h000000, 24'h000000, 1'b1, 1'b1}},
      '{TICK_CMD, 1'b1, NO_PIXEL},
      '{'{FUNC_START, 13'd10, 13'd10, 24'h000064, 13'd4, 13'd16, 24'h000000, 24'hABCDEF},
        1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{'{FUNC_START, 13'd0, 13'd0, 24'h000000, 13'd8, 13'd4, 24'hFFFFFF, 24'h123456},
        1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{'{FUNC_START, 13'h1000, 13'd4095, 24'h000000, 13'd4095, 13'h1000, 24'hFFFFFF, 24'h800001},
        1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{TICK_CMD, 1'b0, NO_PIXEL},
      '{'{FUNC_START, 13'd5, 13'd0, 24'h00F000, 13'd5, 13'd20, 24'h000F00, 24'h0F0F0F},
        1'b0, NO_PIXEL}
   };

   localparam logic [SCREEN_BITS-1:0] PHASE_W [5] = '{12'd1, 12'd2048, 12'd0, 12'd2048, 12'd1};
   localparam logic [SCREEN_BITS-1:0] PHASE_H [5] = '{12'd1, 12'd2048, 12'd7, 12'd1, 12'd2048};

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic                   req_func;
   logic [COORD_W-1:0]     req_start_x;
   logic [COORD_W-1:0]     req_start_y;
   logic [DEPTH_W-1:0]     req_start_depth;
   logic [COORD_W-1:0]     req_end_x;
   logic [COORD_W-1:0]     req_end_y;
   logic [DEPTH_W-1:0]     req_end_depth;
   logic [COLOR_BITS-1:0]  req_line_color;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic                   rsp_active;
   logic [COORD_W-1:0]     rsp_pixel_x;
   logic [COORD_W-1:0]     rsp_pixel_y;
   logic [DEPTH_W-1:0]     rsp_pixel_depth;
   logic [COLOR_BITS-1:0]  rsp_pixel_color;
   logic                   rsp_visible;
   logic                   rsp_last;
   logic                   csr_write_enable;
   logic [0:0]             csr_index;
   logic [SCREEN_BITS-1:0] csr_write_data;

   // Predictor copy of the screen size and the line being drawn.
   logic [SCREEN_BITS-1:0] screen_w = SCREEN_WIDTH_RESET;
   logic [SCREEN_BITS-1:0] screen_h = SCREEN_HEIGHT_RESET;
   logic                   line_on = 1'b0;
   logic signed [12:0]     col = '0;
   logic signed [12:0]     row = '0;
   logic signed [15:0]     decision = '0;
   logic [12:0]            steps = '0;
   logic                   major_col = 1'b0;
   logic                   row_down = 1'b0;
   logic [12:0]            minor_d = '0;
   logic [12:0]            major_d = '0;
   logic [23:0]            zcur = '0;
   logic signed [24:0]     dq = '0;
   logic [12:0]            dr = '0;
   logic [12:0]            dacc = '0;
   logic [23:0]            held_color = '0;

   pixel_type pending_pixels [$];
   pixel_type oldest;
   int        mismatches = 0;
   int        cycle_count = 0;
   bit        calm = 1'b0;
   bit        stall_output = 1'b0;

   line_rasterizer_with_depth i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_start_x      (req_start_x),
      .req_start_y      (req_start_y),
      .req_start_depth  (req_start_depth),
      .req_end_x        (req_end_x),
      .req_end_y        (req_end_y),
      .req_end_depth    (req_end_depth),
      .req_line_color   (req_line_color),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_active       (rsp_active),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_depth  (rsp_pixel_depth),
      .rsp_pixel_color  (rsp_pixel_color),
      .rsp_visible      (rsp_visible),
      .rsp_last         (rsp_last),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   function automatic pixel_type emit_pixel(logic is_last);
      pixel_type px;
      px.active = 1'b1;
      px.x = col;
      px.y = row;
      px.depth = zcur;
      px.color = held_color;
      px.visible = col >= 0 && row >= 0 && int'(col) < int'(screen_w) &&
                   int'(row) < int'(screen_h);
      px.last = is_last;
      return px;
   endfunction

   function automatic pixel_type rasterize_step(line_cmd_type c);
      pixel_type px;
      int        x1, y1, x2, y2, dx, dy, ady, n, t, sum, w, h;
      longint    z1, z2, diff, q, r;
      logic      diag;
      px = NO_PIXEL;
      if (c.func == FUNC_START) begin
         x1 = $signed(c.start_x);
         y1 = $signed(c.start_y);
         x2 = $signed(c.end_x);
         y2 = $signed(c.end_y);
         z1 = c.start_depth;
         z2 = c.end_depth;
         line_on = 1'b0;
         if (x2 < x1) begin
            t = x1; x1 = x2; x2 = t;
            t = y1; y1 = y2; y2 = t;
            diff = z1; z1 = z2; z2 = diff;
         end
         w = screen_w;
         h = screen_h;
         if ((x1 < 0 && x2 < 0) || (y1 < 0 && y2 < 0) || (x1 > w && x2 > w) ||
             (y1 > h && y2 > h)) begin
            return px;
         end
         dx = x2 - x1;
         dy = y2 - y1;
         row_down = dy < 0;
         ady = dy < 0 ? -dy : dy;
         major_col = ady <= dx;
         n = major_col ? dx : ady;
         major_d = 13'(n);
         minor_d = 13'(major_col ? ady : dx);
         decision = 16'(2 * (major_col ? ady : dx) - n);
         col = 13'(x1);
         row = 13'(y1);
         zcur = 24'(z1);
         held_color = c.color;
         steps = 13'(n);
         dacc = '0;
         dq = '0;
         dr = '0;
         if (n > 0) begin
            diff = z2 - z1;
            q = diff / n;
            r = diff % n;
            if (r < 0) begin
               r += n;
               q -= 1;
            end
            dq = 25'(q);
            dr = 13'(r);
         end
         line_on = n > 0;
         return emit_pixel(n == 0);
      end
      if (!line_on || steps == 0) begin
         line_on = 1'b0;
         return px;
      end
      diag = decision >= 0;
      if (diag) begin
         decision = 16'(decision + 2 * (int'(minor_d) - int'(major_d)));
      end else begin
         decision = 16'(decision + 2 * int'(minor_d));
      end
      if (major_col) begin
         col = col + 13'sd1;
         if (diag) row = row_down ? row - 13'sd1 : row + 13'sd1;
      end else begin
         row = row_down ? row - 13'sd1 : row + 13'sd1;
         if (diag) col = col + 13'sd1;
      end
      zcur = zcur + dq[23:0];
      sum = int'(dacc) + int'(dr);
      if (sum >= int'(major_d)) begin
         sum -= int'(major_d);
         zcur = zcur + 24'd1;
      end
      dacc = 13'(sum);
      steps = steps - 13'd1;
      if (steps == 0) line_on = 1'b0;
      return emit_pixel(steps == 0);
   endfunction

   function automatic line_cmd_type random_cmd();
      line_cmd_type c;
      c.func = FUNC_START;
      c.start_x = COORD_W'($urandom);
      c.start_y = COORD_W'($urandom);
      c.start_depth = DEPTH_W'($urandom);
      c.end_x = COORD_W'($urandom);
      c.end_y = COORD_W'($urandom);
      c.end_depth = DEPTH_W'($urandom);
      c.color = COLOR_BITS'($urandom);
      return c;
   endfunction

   task automatic send_cmd(line_cmd_type c, logic known, pixel_type want);
      pixel_type predicted;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_func <= c.func;
      req_start_x <= c.start_x;
      req_start_y <= c.start_y;
      req_start_depth <= c.start_depth;
      req_end_x <= c.end_x;
      req_end_y <= c.end_y;
      req_end_depth <= c.end_depth;
      req_line_color <= c.color;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = rasterize_step(c);
      pending_pixels.insert(pending_pixels.size(), known ? want : predicted);
   endtask

   task automatic wait_all_drawn();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
   endtask

   task automatic set_screen(logic [SCREEN_BITS-1:0] w, logic [SCREEN_BITS-1:0] h);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_write_data <= w;
      @(posedge clock);
      screen_w = w;
      csr_index <= CSR_SCREEN_HEIGHT;
      csr_write_data <= h;
      @(posedge clock);
      screen_h = h;
      csr_write_enable <= 1'b0;
   endtask

   // Mostly complete lines near the screen, with some cut short and some random noise.
   task automatic draw_random(int count);
      int           issued, kind, span, x1, y1, x2, y2, n, t, ticks;
      line_cmd_type c;
      issued = 0;
      while (issued < count) begin
         kind = $urandom_range(0, 19);
         c = random_cmd();
         ticks = 0;
         if (kind == 0) begin
            c.func = FUNC_TICK;
         end else if (kind == 1) begin
            ticks = $urandom_range(0, 4);
         end else begin
            span = (kind == 2) ? 300 : 12;
            x1 = $urandom_range(0, screen_w + 16) - 8;
            y1 = $urandom_range(0, screen_h + 16) - 8;
            x2 = x1 + $urandom_range(0, 2 * span) - span;
            y2 = y1 + $urandom_range(0, 2 * span) - span;
            c.start_x = COORD_W'(x1);
            c.start_y = COORD_W'(y1);
            c.end_x = COORD_W'(x2);
            c.end_y = COORD_W'(y2);
            n = x2 > x1 ? x2 - x1 : x1 - x2;
            t = y2 > y1 ? y2 - y1 : y1 - y2;
            if (t > n) n = t;
            ticks = (kind == 3) ? $urandom_range(0, n) : n + $urandom_range(0, 1);
         end
         send_cmd(c, 1'b0, NO_PIXEL);
         issued++;
         repeat (ticks) begin
            c = random_cmd();
            c.func = FUNC_TICK;
            send_cmd(c, 1'b0, NO_PIXEL);
            issued++;
         end
      end
   endtask

   task automatic check_field(string what, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
         if (mismatches < 10) $display("%s mismatch: expected %h, got %h", what, want, got);
         mismatches++;
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // The receiver either holds off once for a long stretch or idles in short bursts.
   initial begin
      forever begin
         if (stall_output) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            stall_output = 1'b0;
         end else begin
            rsp_ready <= calm || $urandom_range(0, 2) != 0;
            repeat ($urandom_range(1, 10)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            if (mismatches < 10) begin
               $display("unexpected transaction: x %h y %h", rsp_pixel_x, rsp_pixel_y);
            end
            mismatches++;
         end else begin
            oldest = pending_pixels.pop_front();
            check_field("active", oldest.active, rsp_active);
            check_field("pixel_x", oldest.x, rsp_pixel_x);
            check_field("pixel_y", oldest.y, rsp_pixel_y);
            check_field("pixel_depth", oldest.depth, rsp_pixel_depth);
            check_field("pixel_color", oldest.color, rsp_pixel_color);
            check_field("visible", oldest.visible, rsp_visible);
            check_field("last", oldest.last, rsp_last);
         end
      end
   end

   initial begin
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_func <= FUNC_TICK;
      req_start_x <= '0;
      req_start_y <= '0;
      req_start_depth <= '0;
      req_end_x <= '0;
      req_end_y <= '0;
      req_end_depth <= '0;
      req_line_color <= '0;
      csr_write_enable <= 1'b0;
      csr_index <= CSR_SCREEN_WIDTH;
      csr_write_data <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 24; i++) begin
         send_cmd(PLAN[i].cmd, PLAN[i].known, PLAN[i].want);
      end
      for (int p = 0; p < 8; p++) begin
         wait_all_drawn();
         if (p < 5) begin
            set_screen(PHASE_W[p], PHASE_H[p]);
         end else if (p < 7) begin
            set_screen(SCREEN_BITS'($urandom_range(1, 2048)),
                       SCREEN_BITS'($urandom_range(1, 2048)));
         end else begin
            set_screen(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET);
         end
         if (p == 1) stall_output = 1'b1;
         calm = (p == 7);
         draw_random(225);
      end
      wait_all_drawn();
      repeat (40) @(posedge clock);
      if (mismatches == 0 && pending_pixels.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
